// ----- sv/fcs_pkg.sv -----
// fcs_pkg: shared types and constants for the chain solver.
// Used by fcs_ctrl, fcs_dpath and fabrik_chain_solve.
`default_nettype none
package fcs_pkg;
  localparam int MAX_JOINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_FEW       = 2'd2;
  localparam logic [1:0] ST_MANY      = 2'd3;

  localparam logic CFG_TOL   = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD, S_SEGLEN, S_FWD_PIN, S_FWD, S_BWD_PIN, S_BWD, S_CONV, S_EMIT, S_ERR
  } state_t;

  // Datapath operations started by the controller
  typedef enum logic [1:0] {
    OP_LEN, OP_PLACE, OP_CONV
  } op_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [5:0] anchor;
    logic [5:0] moved;
    logic       pin_goal;
    logic       pin_root;
    logic       take_root;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic conv;
  } sts_t;
endpackage
`default_nettype wire

// ----- sv/fcs_sqrt.sv -----
// fcs_sqrt: bit-serial integer square root of a 64-bit value.
// Two result bits per cycle; no package dependency.
`default_nettype none
module fcs_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             busy,
  output logic [31:0]      root
);
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] rem_a, res_a, bit_a, rem_b, res_b;

  // Two restoring steps per cycle
  always_comb begin
    rem_a = rem; res_a = res;
    if (rem >= res + bitv) begin
      rem_a = rem - (res + bitv);
      res_a = (res >> 1) + bitv;
    end else begin
      res_a = res >> 1;
    end
    bit_a = bitv >> 2;
    rem_b = rem_a; res_b = res_a;
    if (rem_a >= res_a + bit_a) begin
      rem_b = rem_a - (res_a + bit_a);
      res_b = (res_a >> 1) + bit_a;
    end else begin
      res_b = res_a >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= radicand;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      rem  <= rem_b;
      res  <= res_b;
      bitv <= bitv >> 4;
      if (bitv[63:4] == '0 || (bitv >> 2) == 64'd1) busy <= 1'b0;
    end
  end

  assign root = res[31:0];
endmodule
`default_nettype wire

// ----- sv/fcs_div.sv -----
// fcs_div: bit-serial unsigned divide, 64-bit dividend by 33-bit divisor.
// One quotient bit per cycle; no package dependency.
`default_nettype none
module fcs_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             busy,
  output logic [63:0]      quot
);
  logic [33:0] rem;
  logic [6:0]  cnt;
  logic [32:0] dsr;
  logic [33:0] trial;

  assign trial = {rem[32:0], quot[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      cnt  <= 7'd64;
    end else if (busy) begin
      // shift one dividend bit in, subtract when it fits
      if (trial >= {1'b0, dsr}) begin
        rem  <= trial - {1'b0, dsr};
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- sv/fcs_dpath.sv -----
// fcs_dpath: joint store, segment lengths and the shared root and divide units.
// Depends on fcs_pkg, fcs_sqrt and fcs_div.
`default_nettype none
module fcs_dpath #(
  parameter int MAX_JOINTS = fcs_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = fcs_pkg::FRAC_BITS_DEF,
  localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fcs_pkg::cmd_t      cmd,
  output fcs_pkg::sts_t           sts,
  input  wire logic               wr_en,
  input  wire logic [IW-1:0]      wr_idx,
  input  wire logic [31:0]        wr_x,
  input  wire logic [31:0]        wr_y,
  input  wire logic [31:0]        wr_z,
  input  wire logic               goal_en,
  input  wire logic [95:0]        goal_in,
  input  wire logic [30:0]        tol,
  input  wire logic [IW-1:0]      rd_idx,
  output logic [31:0]             rd_x,
  output logic [31:0]             rd_y,
  output logic [31:0]             rd_z
);
  localparam int DF_RAW = (1 << FRAC_BITS) / 1000000;
  localparam logic [32:0] DIV_FLOOR = (DF_RAW > 0) ? 33'(DF_RAW) : 33'd1;
  localparam logic [63:0] OFS_LIMIT = 64'd1 << 40;

  typedef enum logic [3:0] {
    P_IDLE, P_RD, P_SQ, P_SQW, P_DIV, P_DIVW, P_WR, P_CSUM, P_CONV
  } pst_t;

  logic signed [31:0] px [MAX_JOINTS];
  logic signed [31:0] py [MAX_JOINTS];
  logic signed [31:0] pz [MAX_JOINTS];
  logic [31:0]        seg [MAX_JOINTS];
  logic signed [31:0] root_pin [3];
  logic signed [31:0] goal [3];

  pst_t               pst;
  fcs_pkg::op_t       op;
  logic [IW-1:0]      ai, mi;
  logic signed [31:0] av [3];
  logic signed [32:0] d [3];
  logic [31:0]        am [3];
  logic [31:0]        a [3];
  logic               sh;
  logic [1:0]         k;
  logic [63:0]        sq_acc;
  logic [32:0]        len;
  logic [31:0        ] segv;
  logic               sq_start, dv_start, sq_busy, dv_busy;
  logic [31:0]        sq_root;
  logic [63:0]        dv_quot, dv_dividend;
  logic               conv_ok, conv_big;
  logic [61:0]        tsq;
  logic [32:0]        mk;
  logic [63:0]        prod;
  logic signed [41:0] nsum;
  logic signed [31:0] nsat;
  logic [63:0]        q;

  // Read port for the output stream
  always_ff @(posedge clk) begin
    rd_x <= px[rd_idx];
    rd_y <= py[rd_idx];
    rd_z <= pz[rd_idx];
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      am[j] = d[j][32] ? 32'(-d[j]) : d[j][31:0];
    end
    mk = d[k][32] ? -d[k] : d[k];
  end

  // One product per cycle into the squared-sum accumulator
  assign prod = 64'(a[k]) * 64'(a[k]);
  assign dv_dividend = 64'(mk[31:0]) * 64'(segv);

  fcs_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .radicand(sq_acc),
                   .busy(sq_busy), .root(sq_root));
  fcs_div u_div (.clk(clk), .rst(rst), .start(dv_start), .dividend(dv_dividend),
                 .divisor(len), .busy(dv_busy), .quot(dv_quot));

  always_comb begin
    q = (dv_quot > OFS_LIMIT) ? OFS_LIMIT : dv_quot;
    nsum = 42'(av[k]) + (d[k][32] ? -42'(q[40:0]) : 42'(q[40:0]));
    if (nsum > 42'sh0_7FFF_FFFF) nsat = 32'sh7FFF_FFFF;
    else if (nsum < -42'sh0_8000_0000) nsat = 32'sh8000_0000;
    else nsat = nsum[31:0];
    tsq = 62'(tol) * 62'(tol);
  end

  assign sq_start = (pst == P_SQW) && (k == 2'd3);
  assign dv_start = (pst == P_DIV);
  assign sts.busy = (pst != P_IDLE) || cmd.start;
  assign sts.conv = conv_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pst <= P_IDLE;
      conv_ok <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        root_pin[j] <= '0;
        goal[j] <= '0;
      end
    end else begin
      if (wr_en) begin
        px[wr_idx] <= wr_x; py[wr_idx] <= wr_y; pz[wr_idx] <= wr_z;
      end
      if (goal_en) begin
        goal[0] <= goal_in[95:64]; goal[1] <= goal_in[63:32]; goal[2] <= goal_in[31:0];
      end
      unique case (pst)
        P_IDLE: begin
          if (cmd.start) begin
            op <= cmd.op;
            ai <= cmd.anchor[IW-1:0];
            mi <= cmd.moved[IW-1:0];
            if (cmd.take_root) begin
              root_pin[0] <= px[0]; root_pin[1] <= py[0]; root_pin[2] <= pz[0];
            end
            // pin the anchor (the tip) to the goal
            if (cmd.pin_goal) begin
              px[cmd.anchor[IW-1:0]] <= goal[0];
              py[cmd.anchor[IW-1:0]] <= goal[1];
              pz[cmd.anchor[IW-1:0]] <= goal[2];
            end
            if (cmd.pin_root) begin
              px[0] <= root_pin[0]; py[0] <= root_pin[1]; pz[0] <= root_pin[2];
            end
            pst <= P_RD;
          end
        end
        P_RD: begin
          // differences moved minus anchor (goal for the convergence test)
          if (op == fcs_pkg::OP_CONV) begin
            d[0] <= 33'(px[mi]) - 33'(goal[0]);
            d[1] <= 33'(py[mi]) - 33'(goal[1]);
            d[2] <= 33'(pz[mi]) - 33'(goal[2]);
          end else begin
            d[0] <= 33'(px[mi]) - 33'(px[ai]);
            d[1] <= 33'(py[mi]) - 33'(py[ai]);
            d[2] <= 33'(pz[mi]) - 33'(pz[ai]);
          end
          av[0] <= px[ai]; av[1] <= py[ai]; av[2] <= pz[ai];
          segv <= (op == fcs_pkg::OP_LEN) ? seg[ai] : seg[(op == fcs_pkg::OP_PLACE &&
                  mi < ai) ? mi : ai];
          pst <= (op == fcs_pkg::OP_CONV) ? P_CSUM : P_SQ;
          k <= 2'd3;
          sq_acc <= '0;
        end
        P_SQ: begin
          if (k == 2'd3) begin
            sh <= am[0][31] | am[1][31] | am[2][31];
            for (int j = 0; j < 3; j++)
              a[j] <= (am[0][31] | am[1][31] | am[2][31]) ? (am[j] >> 1) : am[j];
            k <= 2'd0;
          end else begin
            sq_acc <= sq_acc + prod;
            if (k == 2'd2) pst <= P_SQW;
            k <= k + 2'd1;
          end
        end
        P_SQW: begin
          if (k == 2'd3) begin
            // start the root with the completed sum
            k <= 2'd0;
          end else if (!sq_busy) begin
            if (op == fcs_pkg::OP_LEN) begin
              seg[ai] <= sh && sq_root[31] ? 32'hFFFF_FFFF
                         : (sh ? {sq_root[30:0], 1'b0} : sq_root);
              pst <= P_IDLE;
            end else begin
              if (({1'b0, sq_root} << sh) < DIV_FLOOR) len <= DIV_FLOOR;
              else len <= {1'b0, sq_root} << sh;
              pst <= P_DIV;
            end
          end
        end
        P_DIV: pst <= P_DIVW;
        P_DIVW: begin
          if (!dv_busy) pst <= P_WR;
        end
        P_WR: begin
          unique case (k)
            2'd0: px[mi] <= nsat;
            2'd1: py[mi] <= nsat;
            default: pz[mi] <= nsat;
          endcase
          if (k == 2'd2) pst <= P_IDLE;
          else begin
            k <= k + 2'd1;
            pst <= P_DIV;
          end
        end
        P_CSUM: begin
          if (k == 2'd3) begin
            conv_big <= am[0][31] | am[1][31] | am[2][31];
            for (int j = 0; j < 3; j++) a[j] <= am[j];
            k <= 2'd0;
          end else begin
            sq_acc <= sq_acc + prod;
            if (k == 2'd2) pst <= P_CONV;
            k <= k + 2'd1;
          end
        end
        P_CONV: begin
          conv_ok <= !conv_big && (sq_acc < 64'(tsq));
          pst <= P_IDLE;
        end
        default: pst <= P_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/fcs_ctrl.sv -----
// fcs_ctrl: sequencer for loading, segment lengths, passes and result stream.
// Depends on fcs_pkg.
`default_nettype none
module fcs_ctrl #(
  parameter int MAX_JOINTS = fcs_pkg::MAX_JOINTS_DEF,
  localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1,
  localparam int CW = $clog2(MAX_JOINTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          in_last,
  input  wire logic [7:0]    limit,
  input  wire fcs_pkg::sts_t sts,
  output fcs_pkg::cmd_t      cmd,
  output logic               in_ready,
  output logic               wr_en,
  output logic [IW-1:0]      wr_idx,
  output logic               goal_en,
  output logic [IW-1:0]      rd_idx,
  output logic               out_load,
  output logic [3:0]         out_idx,
  output logic [1:0]         out_status,
  output logic               out_last,
  input  wire logic          out_free
);
  fcs_pkg::state_t state, state_next;
  logic [CW-1:0] cnt, n;
  logic          ovf;
  logic [5:0]    i;
  logic [7:0]    iters;
  logic          issued, rd_pend;
  logic [1:0]    status;

  assign in_ready = (state == fcs_pkg::S_LOAD);
  assign wr_en    = in_fire && (cnt < CW'(MAX_JOINTS));
  assign wr_idx   = cnt[IW-1:0];
  assign goal_en  = in_fire && in_last;
  assign rd_idx   = i[IW-1:0];

  // Command to the datapath: one operation at a time
  always_comb begin
    cmd = '0;
    cmd.anchor = i;
    cmd.moved  = i;
    state_next = state;
    out_load = 1'b0;
    out_idx = i[3:0];
    out_status = status;
    out_last = 1'b0;
    unique case (state)
      fcs_pkg::S_LOAD: begin
        if (in_fire && in_last) begin
          if (ovf || !wr_en || cnt + 1'b1 < CW'(2))
            state_next = fcs_pkg::S_ERR;
          else state_next = fcs_pkg::S_SEGLEN;
        end
      end
      fcs_pkg::S_SEGLEN: begin
        cmd.op = fcs_pkg::OP_LEN;
        cmd.anchor = i; cmd.moved = i + 6'd1;
        cmd.take_root = (i == 6'd0);
        cmd.start = !issued;
      end
      fcs_pkg::S_FWD_PIN: begin
        cmd.op = fcs_pkg::OP_PLACE;
        cmd.pin_goal = 1'b1;
        cmd.anchor = 6'(n) - 6'd1; cmd.moved = 6'(n) - 6'd2;
        cmd.start = !issued;
      end
      fcs_pkg::S_FWD: begin
        cmd.op = fcs_pkg::OP_PLACE;
        cmd.anchor = i; cmd.moved = i - 6'd1;
        cmd.start = !issued;
      end
      fcs_pkg::S_BWD_PIN: begin
        cmd.op = fcs_pkg::OP_PLACE;
        cmd.pin_root = 1'b1;
        cmd.anchor = 6'd0; cmd.moved = 6'd1;
        cmd.start = !issued;
      end
      fcs_pkg::S_BWD: begin
        cmd.op = fcs_pkg::OP_PLACE;
        cmd.anchor = i; cmd.moved = i + 6'd1;
        cmd.start = !issued;
      end
      fcs_pkg::S_CONV: begin
        cmd.op = fcs_pkg::OP_CONV;
        cmd.moved = 6'(n) - 6'd1;
        cmd.start = !issued;
      end
      fcs_pkg::S_EMIT: begin
        out_load = out_free && rd_pend;
        out_last = (i + 6'd1 == 6'(n));
      end
      fcs_pkg::S_ERR: begin
        out_load = out_free;
        out_idx = '0;
        out_status = status;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcs_pkg::S_LOAD;
      cnt <= '0; ovf <= 1'b0; issued <= 1'b0; i <= '0; n <= '0;
      iters <= '0; status <= fcs_pkg::ST_CONVERGED; rd_pend <= 1'b0;
    end else begin
      if (cmd.start) issued <= 1'b1;
      unique case (state)
        fcs_pkg::S_LOAD: begin
          if (in_fire) begin
            if (in_last) begin
              n <= wr_en ? cnt + 1'b1 : cnt;
              status <= ovf || !wr_en ? fcs_pkg::ST_MANY : fcs_pkg::ST_FEW;
              cnt <= '0; ovf <= 1'b0; i <= '0; issued <= 1'b0; iters <= '0;
              state <= state_next;
            end else if (wr_en) cnt <= cnt + 1'b1;
            else ovf <= 1'b1;
          end
        end
        fcs_pkg::S_SEGLEN: begin
          if (issued && !sts.busy) begin
            issued <= 1'b0;
            if (i + 6'd2 == 6'(n)) begin
              i <= '0;
              if (limit == 8'd0) begin
                status <= fcs_pkg::ST_LIMIT;
                state <= fcs_pkg::S_EMIT;
              end else state <= fcs_pkg::S_FWD_PIN;
            end else i <= i + 6'd1;
          end
        end
        fcs_pkg::S_FWD_PIN: begin
          if (issued && !sts.busy) begin
            issued <= 1'b0;
            i <= 6'(n) - 6'd2;
            state <= (n == CW'(2)) ? fcs_pkg::S_BWD_PIN : fcs_pkg::S_FWD;
          end
        end
        fcs_pkg::S_FWD: begin
          if (issued && !sts.busy) begin
            issued <= 1'b0;
            if (i == 6'd1) state <= fcs_pkg::S_BWD_PIN;
            else i <= i - 6'd1;
          end
        end
        fcs_pkg::S_BWD_PIN: begin
          if (issued && !sts.busy) begin
            issued <= 1'b0;
            i <= 6'd1;
            state <= (n == CW'(2)) ? fcs_pkg::S_CONV : fcs_pkg::S_BWD;
          end
        end
        fcs_pkg::S_BWD: begin
          if (issued && !sts.busy) begin
            issued <= 1'b0;
            if (i + 6'd2 == 6'(n)) state <= fcs_pkg::S_CONV;
            else i <= i + 6'd1;
          end
        end
        fcs_pkg::S_CONV: begin
          if (issued && !sts.busy) begin
            issued <= 1'b0;
            iters <= iters + 8'd1;
            i <= '0;
            if (sts.conv) begin
              status <= fcs_pkg::ST_CONVERGED; state <= fcs_pkg::S_EMIT;
            end else if (iters + 8'd1 == limit) begin
              status <= fcs_pkg::ST_LIMIT; state <= fcs_pkg::S_EMIT;
            end else state <= fcs_pkg::S_FWD_PIN;
          end
        end
        fcs_pkg::S_EMIT: begin
          // wait for the registered read, then hand the word over
          if (!rd_pend) rd_pend <= 1'b1;
          else if (out_load) begin
            rd_pend <= 1'b0;
            if (out_last) begin
              i <= '0; state <= fcs_pkg::S_LOAD;
            end else i <= i + 6'd1;
          end
        end
        fcs_pkg::S_ERR: begin
          if (out_free) state <= fcs_pkg::S_LOAD;
        end
        default: state <= fcs_pkg::S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/fabrik_chain_solve.sv -----
// fabrik_chain_solve: top level of the fixed-point FABRIK chain solver.
// Depends on fcs_pkg, fcs_ctrl and fcs_dpath.
`default_nettype none
// Joints load one word per cycle, root first; the word with last_joint set
// carries the goal and starts the solve. Each joint placement runs through one
// shared bit-serial square root and three divides on the shared bit-serial
// divider; a solve makes two passes per iteration, up to iteration_limit
// iterations, and the result words then leave one at a time. Input is not
// taken while a solve is running.
module fabrik_chain_solve #(
  parameter int MAX_JOINTS = fcs_pkg::MAX_JOINTS_DEF,
  parameter int COORD_FRAC_BITS = fcs_pkg::FRAC_BITS_DEF,
  localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] joint_x,
  input  wire logic [31:0] joint_y,
  input  wire logic [31:0] joint_z,
  input  wire logic [31:0] target_x,
  input  wire logic [31:0] target_y,
  input  wire logic [31:0] target_z,
  input  wire logic        last_joint,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [3:0]       joint_index,
  output logic [1:0]       solve_status,
  output logic             last_result
);
  logic [30:0] tol;
  logic [7:0]  limit;
  fcs_pkg::cmd_t cmd;
  fcs_pkg::sts_t sts;
  logic wr_en, goal_en, out_load, out_lst, err;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [31:0] rd_x, rd_y, rd_z;
  logic [3:0]  o_idx;
  logic [1:0]  o_st;
  logic        in_fire, out_free;

  assign cfg_ready = 1'b1;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 31'd65; limit <= 8'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fcs_pkg::CFG_TOL:   tol   <= cfg_data[30:0];
        fcs_pkg::CFG_LIMIT: limit <= cfg_data[7:0];
      endcase
    end
  end

  fcs_ctrl #(.MAX_JOINTS(MAX_JOINTS)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(last_joint), .limit(limit),
    .sts(sts), .cmd(cmd), .in_ready(in_ready), .wr_en(wr_en), .wr_idx(wr_idx),
    .goal_en(goal_en), .rd_idx(rd_idx), .out_load(out_load), .out_idx(o_idx),
    .out_status(o_st), .out_last(out_lst), .out_free(out_free));

  fcs_dpath #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(COORD_FRAC_BITS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .wr_en(wr_en), .wr_idx(wr_idx),
    .wr_x(joint_x), .wr_y(joint_y), .wr_z(joint_z), .goal_en(goal_en),
    .goal_in({target_x, target_y, target_z}), .tol(tol), .rd_idx(rd_idx),
    .rd_x(rd_x), .rd_y(rd_y), .rd_z(rd_z));

  assign err = (o_st == fcs_pkg::ST_FEW) || (o_st == fcs_pkg::ST_MANY);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_x <= err ? '0 : rd_x;
      out_y <= err ? '0 : rd_y;
      out_z <= err ? '0 : rd_z;
      joint_index <= o_idx;
      solve_status <= o_st;
      last_result <= out_lst;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_load_emit: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.start) else $error("solve while loading");
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (solve_status == fcs_pkg::ST_FEW) |-> last_result)
    else $error("error not final");
endmodule
`default_nettype wire

// ----- verif/tb_fabrik_chain_solve.sv -----
// tb_fabrik_chain_solve: self-checking testbench for the FABRIK chain solver.
// Depends on fcs_pkg and fabrik_chain_solve; a local fixed-point predictor
// supplies the expected joint words.
module tb_fabrik_chain_solve;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = fcs_pkg::MAX_JOINTS_DEF;

  typedef struct {
    logic [31:0] jx, jy, jz, tx, ty, tz;
    logic        last;
    logic        typed;   // expected status typed in below, not predicted
    logic [1:0]  tstat;
  } joint_word_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [3:0]  idx;
    logic [1:0]  status;
    logic        last;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0, cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 1'b0, last_joint = 1'b0;
  logic [31:0] joint_x = '0, joint_y = '0, joint_z = '0;
  logic [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic in_ready, out_valid, out_ready = 1'b0, last_result;
  logic [31:0] out_x, out_y, out_z;
  logic [3:0] joint_index;
  logic [1:0] solve_status;

  fabrik_chain_solve i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Solver mirror: pose, segment lengths, goal and registers
  logic signed [31:0] pose [3][NJ];
  logic [31:0]        seg_len [NJ];
  logic signed [31:0] goal [3];
  int                 n_loaded;
  logic               dropped;
  logic [30:0]        tol_reg;
  logic [7:0]         iter_reg;
  pose_word_t         pending_q [$];
  int                 mismatches;
  logic               calm;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dist3(longint d0, longint d1, longint d2);
    longint unsigned a0, a1, a2;
    int sh;
    a0 = mag(d0); a1 = mag(d1); a2 = mag(d2);
    sh = 0;
    if (a0 >= 64'h80000000 || a1 >= 64'h80000000 || a2 >= 64'h80000000) begin
      sh = 1;
      a0 = a0 >> 1; a1 = a1 >> 1; a2 = a2 >> 1;
    end
    return int_sqrt(a0 * a0 + a1 * a1 + a2 * a2) << sh;
  endfunction

  function automatic longint span(int k, int a, int b);
    return longint'(pose[k][b]) - longint'(pose[k][a]);
  endfunction

  // Pull joint m along the line from anchor a until it sits at distance seg
  function automatic void pull_joint(int a, int m, logic [31:0] seg);
    longint d [3];
    longint unsigned dl, q;
    for (int k = 0; k < 3; k++) d[k] = span(k, a, m);
    dl = dist3(d[0], d[1], d[2]);
    if (dl < 1) dl = 1;
    for (int k = 0; k < 3; k++) begin
      q = mag(d[k]) * longint'({32'd0, seg}) / dl;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      pose[k][m] = clamp32(longint'(pose[k][a]) + (d[k] < 0 ? -longint'(q) : longint'(q)));
    end
  endfunction

  function automatic logic tip_on_goal(int tip);
    longint unsigned sum, m, t;
    sum = 0;
    t = tol_reg;
    for (int k = 0; k < 3; k++) begin
      m = mag(longint'(pose[k][tip]) - longint'(goal[k]));
      if (m >= 64'h80000000) return 1'b0;
      sum = sum + m * m;
    end
    return sum < t * t;
  endfunction

  function automatic logic [1:0] solve_chain(int n);
    logic signed [31:0] root [3];
    longint unsigned l;
    for (int i = 0; i + 1 < n; i++) begin
      l = dist3(span(0, i, i + 1), span(1, i, i + 1), span(2, i, i + 1));
      seg_len[i] = l > 64'hFFFFFFFF ? 32'hFFFFFFFF : l[31:0];
    end
    for (int k = 0; k < 3; k++) root[k] = pose[k][0];
    for (int it = 0; it < iter_reg; it++) begin
      for (int k = 0; k < 3; k++) pose[k][n - 1] = goal[k];
      for (int i = n - 1; i > 0; i--) pull_joint(i, i - 1, seg_len[i - 1]);
      for (int k = 0; k < 3; k++) pose[k][0] = root[k];
      for (int i = 0; i + 1 < n; i++) pull_joint(i, i + 1, seg_len[i]);
      if (tip_on_goal(n - 1)) return fcs_pkg::ST_CONVERGED;
    end
    return fcs_pkg::ST_LIMIT;
  endfunction

  // Load one joint word and queue the solved pose, or an error word, when it closes the chain
  function automatic void load_joint(joint_word_t w);
    pose_word_t r;
    logic [1:0] st;
    int n;
    if (n_loaded < NJ) begin
      pose[0][n_loaded] = w.jx;
      pose[1][n_loaded] = w.jy;
      pose[2][n_loaded] = w.jz;
      n_loaded++;
    end else begin
      dropped = 1'b1;
    end
    if (!w.last) return;
    goal[0] = w.tx; goal[1] = w.ty; goal[2] = w.tz;
    n = n_loaded;
    n_loaded = 0;
    if (dropped || n < 2) begin
      r = '{x: '0, y: '0, z: '0, idx: '0, last: 1'b1,
            status: dropped ? fcs_pkg::ST_MANY : fcs_pkg::ST_FEW};
      dropped = 1'b0;
      if (w.typed) r.status = w.tstat;
      pending_q.push_back(r);
      return;
    end
    st = solve_chain(n);
    for (int k = 0; k < n; k++) begin
      r.x = pose[0][k]; r.y = pose[1][k]; r.z = pose[2][k];
      r.idx = k[3:0];
      r.status = st;
      r.last = (k == n - 1);
      pending_q.push_back(r);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    pose_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected word", {28'd0, joint_index}, '0);
      end else begin
        e = pending_q.pop_front();
        if (out_x !== e.x) report("out_x", out_x, e.x);
        if (out_y !== e.y) report("out_y", out_y, e.y);
        if (out_z !== e.z) report("out_z", out_z, e.z);
        if (joint_index !== e.idx)
          report("joint_index", {28'd0, joint_index}, {28'd0, e.idx});
        if (solve_status !== e.status)
          report("solve_status", {30'd0, solve_status}, {30'd0, e.status});
        if (last_result !== e.last)
          report("last_result", {31'd0, last_result}, {31'd0, e.last});
      end
    end
  end

  // Stall the result side at random, unless in a calm stretch
  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 38);

  task automatic send_word(joint_word_t w);
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    joint_x <= w.jx; joint_y <= w.jy; joint_z <= w.jz;
    target_x <= w.tx; target_y <= w.ty; target_z <= w.tz;
    last_joint <= w.last;
    do @(posedge clk); while (!in_ready);
    load_joint(w);
  endtask

  // Hold input until every expected word is back, then let the block settle
  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fcs_pkg::CFG_TOL) tol_reg = data[30:0];
    else iter_reg = data[7:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 99) < 20) return $urandom;
    return $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
  endfunction

  function automatic joint_word_t rand_word(logic last);
    joint_word_t w;
    w = '{jx: rand_coord(), jy: rand_coord(), jz: rand_coord(),
          tx: rand_coord(), ty: rand_coord(), tz: rand_coord(),
          last: last, typed: 1'b0, tstat: fcs_pkg::ST_CONVERGED};
    return w;
  endfunction

  task automatic run_chain(int n);
    for (int j = 0; j < n; j++) send_word(rand_word(j == n - 1));
  endtask

  task automatic random_phase(int words, int longest);
    int sent, n, pick;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) n = 1;
      else if (pick < 75) n = $urandom_range(2, 5);
      else if (pick < 90) n = $urandom_range(6, longest);
      else n = $urandom_range(NJ + 1, NJ + 2);
      // wait for the block to empty before some chains
      if ($urandom_range(0, 9) == 0) drain(0);
      run_chain(n);
      sent += n;
    end
  endtask

  function automatic joint_word_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                     logic last);
    joint_word_t w;
    w = '{jx: x, jy: y, jz: z, tx: gx, ty: gy, tz: gz, last: last,
          typed: 1'b0, tstat: fcs_pkg::ST_CONVERGED};
    return w;
  endfunction

  initial begin
    joint_word_t plan [$];
    joint_word_t w;
    mismatches = 0;
    n_loaded = 0;
    dropped = 1'b0;
    tol_reg = 31'd65;
    iter_reg = 8'd16;
    calm = 1'b0;
    for (int k = 0; k < 3; k++) goal[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: lone joint, extremes, a plain chain, a zero-length chain, then an overlong one
    w = mk(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'h2, 32'h3, 1'b1);
    w.typed = 1'b1; w.tstat = fcs_pkg::ST_FEW;
    plan.push_back(w);
    plan.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, '0, '0, '0, 1'b0));
    plan.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b1));
    plan.push_back(mk(32'h0, 32'h0, 32'h0, '0, '0, '0, 1'b0));
    plan.push_back(mk(32'h0001_0000, 32'h0, 32'h0, '0, '0, '0, 1'b0));
    plan.push_back(mk(32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1));
    plan.push_back(mk(32'h0, 32'h0, 32'h0, '0, '0, '0, 1'b0));
    plan.push_back(mk(32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 1'b1));
    for (int j = 0; j <= NJ; j++) begin
      w = mk(j << 16, 32'hFFFF_0000, 32'h0, '0, '0, '0, j == NJ);
      if (j == NJ) begin
        w.typed = 1'b1; w.tstat = fcs_pkg::ST_MANY;
      end
      plan.push_back(w);
    end
    foreach (plan[i]) send_word(plan[i]);
    drain(60);

    // Widest tolerance, longest limit
    write_reg(fcs_pkg::CFG_TOL, 32'h7FFFFFFF);
    write_reg(fcs_pkg::CFG_LIMIT, 32'd255);
    random_phase(76, 16);
    drain(60);

    // No iterations: the loaded pose comes back untouched
    write_reg(fcs_pkg::CFG_TOL, 32'd0);
    write_reg(fcs_pkg::CFG_LIMIT, 32'd0);
    random_phase(76, 16);
    drain(60);

    // Calm stretch with no random stalls on either side
    calm = 1'b1;
    write_reg(fcs_pkg::CFG_TOL, 32'h0000_4000);
    write_reg(fcs_pkg::CFG_LIMIT, 32'd3);
    random_phase(76, 10);
    drain(60);
    calm = 1'b0;

    write_reg(fcs_pkg::CFG_TOL, $urandom & 32'h0003_FFFF);
    write_reg(fcs_pkg::CFG_LIMIT, 32'd2);
    random_phase(76, 12);
    drain(60);

    write_reg(fcs_pkg::CFG_TOL, 32'd65);
    write_reg(fcs_pkg::CFG_LIMIT, 32'd1);
    random_phase(60, 16);
    drain(60);

    // Unreachable goal with no tolerance runs the full limit once
    write_reg(fcs_pkg::CFG_TOL, 32'd0);
    write_reg(fcs_pkg::CFG_LIMIT, 32'd255);
    send_word(mk(32'h0, 32'h0, 32'h0, '0, '0, '0, 1'b0));
    send_word(mk(32'h0001_0000, 32'h0, 32'h0, 32'h0050_0000, 32'h0, 32'h0, 1'b1));
    drain(200);

    if (mismatches == 0) $display("fabrik_chain_solve test passed");
    else $display("fabrik_chain_solve test failed");
    $finish;
  end

  initial begin
    #1s;
    $display("fabrik_chain_solve test failed");
    $finish;
  end
endmodule
